/* src/alfl_pkg.sv */
// Package for the array linked list with free list.
// Holds the command and status codes and the request and response structs.
// No dependencies.
package alfl_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FOUND_W = 8;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_RM_FRONT  = 3'd2,
    CMD_RM_BACK   = 3'd3,
    CMD_RM_CUR    = 3'd4,
    CMD_SEARCH    = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_READ_CUR  = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_CURSOR = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic [FOUND_W-1:0]       found_slot;
    logic                     cursor_valid;
    logic signed [DATA_W-1:0] cursor_data;
    logic                     list_empty;
  } rsp_t;

endpackage

/* src/array_linked_list_free_list.sv */
// Linked list in a node store with a free list; uses alfl_pkg and alfl_ram.
// A request completes with done_o after the decode, finish and output states, and walks
// the nodes one by one for back insert, back/current removal, search and clear.
// One request at a time; busy rises once a request is accepted and stays high through the done_o cycle.
// Each step of a walk waits on the registered read of the link memory. done_o cannot be stalled.
// Reset empties the list, cursor and free list; the node memories are not cleared.
module array_linked_list_free_list #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  alfl_pkg::req_t req_i,
  output logic          done_o,
  output alfl_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned SW = $clog2(CAPACITY + 1);
  localparam logic [SW-1:0] NIL = SW'(CAPACITY);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_WTAIL  = 4'd2;
  localparam logic [3:0] S_WBACK  = 4'd3;
  localparam logic [3:0] S_WCUR   = 4'd4;
  localparam logic [3:0] S_UNLINK = 4'd5;
  localparam logic [3:0] S_FREEN  = 4'd6;
  localparam logic [3:0] S_SEARCH = 4'd7;
  localparam logic [3:0] S_CLEAR  = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  function automatic logic [alfl_pkg::FOUND_W-1:0] low_byte(logic [SW-1:0] s);
    logic [SW+alfl_pkg::FOUND_W-1:0] e;
    e = {{alfl_pkg::FOUND_W{1'b0}}, s};
    return e[alfl_pkg::FOUND_W-1:0];
  endfunction

  logic [3:0]                        state_q, state_d;
  alfl_pkg::cmd_e                    cmd_q, cmd_d;
  logic signed [alfl_pkg::DATA_W-1:0] val_q, val_d;
  logic [SW-1:0]                     head_q, head_d;
  logic [SW-1:0]                     cur_q, cur_d;
  logic [SW-1:0]                     free_q, free_d;
  logic [SW-1:0]                     hw_q, hw_d;
  logic [SW-1:0]                     p_q, p_d;
  logic [SW-1:0]                     n_q, n_d;
  alfl_pkg::status_e                 status_q, status_d;
  logic [alfl_pkg::FOUND_W-1:0]      found_q, found_d;

  logic                        lw_en;
  logic [SW-1:0]               lw_slot;
  logic [SW-1:0]               lw_data;
  logic [SW-1:0]               lr_slot;
  logic [SW-1:0]               link_rd;
  logic                        dw_en;
  logic [SW-1:0]               dw_slot;
  logic [SW-1:0]               dr_slot;
  logic [alfl_pkg::DATA_W-1:0] data_rd;
  logic [SW-1:0]               new_slot;
  logic                        have_slot;

  alfl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (lw_en),
    .waddr_i(lw_slot[AW-1:0]),
    .wdata_i(lw_data),
    .raddr_i(lr_slot[AW-1:0]),
    .rdata_o(link_rd)
  );

  alfl_ram #(.WIDTH(alfl_pkg::DATA_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (dw_en),
    .waddr_i(dw_slot[AW-1:0]),
    .wdata_i(val_q),
    .raddr_i(dr_slot[AW-1:0]),
    .rdata_o(data_rd)
  );

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    val_d     = val_q;
    head_d    = head_q;
    cur_d     = cur_q;
    free_d    = free_q;
    hw_d      = hw_q;
    p_d       = p_q;
    n_d       = n_q;
    status_d  = status_q;
    found_d   = found_q;
    lw_en     = 1'b0;
    lw_slot   = head_q;
    lw_data   = free_q;
    lr_slot   = head_q;
    dw_en     = 1'b0;
    dw_slot   = free_q;
    dr_slot   = head_q;
    new_slot  = free_q;
    have_slot = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.cmd == alfl_pkg::CMD_INS_FRONT || req_i.cmd == alfl_pkg::CMD_INS_BACK) begin
          lr_slot = free_q;
        end
        if (start) begin
          cmd_d    = req_i.cmd;
          val_d    = req_i.value;
          status_d = alfl_pkg::ST_OK;
          found_d  = '0;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_FIN;
        unique case (cmd_q)
          alfl_pkg::CMD_INS_FRONT, alfl_pkg::CMD_INS_BACK: begin
            if (free_q != NIL) begin
              new_slot  = free_q;
              free_d    = link_rd;
              have_slot = 1'b1;
            end else if (hw_q != NIL) begin
              new_slot  = hw_q;
              hw_d      = hw_q + SW'(1);
              have_slot = 1'b1;
            end else begin
              status_d = alfl_pkg::ST_FULL;
            end
            if (have_slot) begin
              dw_en   = 1'b1;
              dw_slot = new_slot;
              cur_d   = new_slot;
              found_d = low_byte(new_slot);
              lw_en   = 1'b1;
              lw_slot = new_slot;
              if (cmd_q == alfl_pkg::CMD_INS_FRONT || head_q == NIL) begin
                lw_data = head_q;
                head_d  = new_slot;
              end else begin
                lw_data = NIL;
                n_d     = new_slot;
                p_d     = head_q;
                lr_slot = head_q;
                state_d = S_WTAIL;
              end
            end
          end
          alfl_pkg::CMD_RM_FRONT, alfl_pkg::CMD_RM_BACK, alfl_pkg::CMD_RM_CUR: begin
            if (head_q == NIL) begin
              status_d = alfl_pkg::ST_EMPTY;
            end else if (cmd_q == alfl_pkg::CMD_RM_CUR && cur_q == NIL) begin
              status_d = alfl_pkg::ST_NO_CURSOR;
            end else if (cmd_q == alfl_pkg::CMD_RM_FRONT
                         || (cmd_q == alfl_pkg::CMD_RM_BACK && link_rd == NIL)
                         || (cmd_q == alfl_pkg::CMD_RM_CUR && cur_q == head_q)) begin
              lw_en   = 1'b1;
              lw_slot = head_q;
              lw_data = free_q;
              free_d  = head_q;
              head_d  = link_rd;
              cur_d   = link_rd;
            end else if (cmd_q == alfl_pkg::CMD_RM_BACK) begin
              p_d     = head_q;
              n_d     = link_rd;
              lr_slot = link_rd;
              state_d = S_WBACK;
            end else begin
              p_d     = head_q;
              lr_slot = head_q;
              state_d = S_WCUR;
            end
          end
          alfl_pkg::CMD_SEARCH: begin
            p_d     = head_q;
            lr_slot = head_q;
            dr_slot = head_q;
            state_d = S_SEARCH;
          end
          alfl_pkg::CMD_CLEAR: begin
            lr_slot = head_q;
            state_d = S_CLEAR;
          end
          alfl_pkg::CMD_READ_CUR: begin
            if (cur_q == NIL) begin
              status_d = alfl_pkg::ST_NO_CURSOR;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_WTAIL: begin
        if (link_rd == NIL) begin
          lw_en   = 1'b1;
          lw_slot = p_q;
          lw_data = n_q;
          state_d = S_FIN;
        end else begin
          p_d     = link_rd;
          lr_slot = link_rd;
        end
      end
      S_WBACK: begin
        if (link_rd == NIL) begin
          lw_en   = 1'b1;
          lw_slot = p_q;
          lw_data = NIL;
          state_d = S_FREEN;
        end else begin
          p_d     = n_q;
          n_d     = link_rd;
          lr_slot = link_rd;
        end
      end
      S_WCUR: begin
        if (link_rd == cur_q) begin
          n_d     = cur_q;
          lr_slot = cur_q;
          state_d = S_UNLINK;
        end else if (link_rd == NIL) begin
          status_d = alfl_pkg::ST_NO_CURSOR;
          state_d  = S_FIN;
        end else begin
          p_d     = link_rd;
          lr_slot = link_rd;
        end
      end
      S_UNLINK: begin
        lw_en   = 1'b1;
        lw_slot = p_q;
        lw_data = link_rd;
        state_d = S_FREEN;
      end
      S_FREEN: begin
        lw_en   = 1'b1;
        lw_slot = n_q;
        lw_data = free_q;
        free_d  = n_q;
        cur_d   = p_q;
        state_d = S_FIN;
      end
      S_SEARCH: begin
        if (p_q == NIL) begin
          status_d = alfl_pkg::ST_NOT_FOUND;
          state_d  = S_FIN;
        end else if (data_rd == val_q) begin
          cur_d   = p_q;
          found_d = low_byte(p_q);
          state_d = S_FIN;
        end else begin
          p_d     = link_rd;
          lr_slot = link_rd;
          dr_slot = link_rd;
        end
      end
      S_CLEAR: begin
        if (head_q == NIL) begin
          cur_d   = NIL;
          state_d = S_FIN;
        end else begin
          lw_en   = 1'b1;
          lw_slot = head_q;
          lw_data = free_q;
          free_d  = head_q;
          head_d  = link_rd;
          lr_slot = link_rd;
        end
      end
      S_FIN: begin
        dr_slot = cur_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NIL;
      cur_q   <= NIL;
      free_q  <= NIL;
      hw_q    <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cur_q   <= cur_d;
      free_q  <= free_d;
      hw_q    <= hw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    p_q      <= p_d;
    n_q      <= n_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

  always_comb begin
    rsp_o.status       = status_q;
    rsp_o.found_slot   = found_q;
    rsp_o.cursor_valid = (cur_q != NIL);
    rsp_o.cursor_data  = (cur_q != NIL) ? data_rd : '0;
    rsp_o.list_empty   = (head_q == NIL);
  end

`ifndef NO_ASSERTIONS
  a_link_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lw_en |-> (lw_slot != NIL))
    else $error("link write to null slot");

  a_high_water_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= NIL)
    else $error("high-water count beyond capacity");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
`endif

endmodule

/* src/alfl_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered. No dependencies.
module alfl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* dv/array_linked_list_free_list_tb.sv */
// Testbench for the array linked list with free list; depends on alfl_pkg and the block's RTL.
// A list tracker predicts each response from its own copy of the node store, free list and cursor,
// and checks every done_o response in order while directed and random requests are driven.
module array_linked_list_free_list_tb;
  import alfl_pkg::*;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned NIL      = CAPACITY;

  localparam int MODE_GROW   = 0;
  localparam int MODE_MIX    = 1;
  localparam int MODE_SHRINK = 2;

  localparam int PHASE_ITEMS = 325;

  class list_tracker;
    logic [DATA_W-1:0] data_q [NIL];
    logic [8:0]        link_q [NIL];
    int unsigned       head;
    int unsigned       cursor;
    int unsigned       free_head;
    int unsigned       high_water;
    int unsigned       node_count;
    rsp_t              pending_rsp [$];
    int unsigned       errors;

    function new();
      head       = NIL;
      cursor     = NIL;
      free_head  = NIL;
      high_water = 0;
      node_count = 0;
      errors     = 0;
    endfunction

    function int unsigned next_of(int unsigned s);
      return (s < NIL) ? int'(link_q[s]) : NIL;
    endfunction

    function bit take_slot(output int unsigned s);
      s = NIL;
      if (free_head < NIL) begin
        s = free_head;
        free_head = link_q[free_head];
        return 1'b1;
      end
      if (high_water < NIL) begin
        s = high_water;
        high_water++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void release_slot(int unsigned s);
      if (s < NIL) begin
        link_q[s] = 9'(free_head);
        free_head = s;
        node_count--;
      end
    endfunction

    function void drop_head();
      int unsigned nxt;
      nxt = next_of(head);
      release_slot(head);
      head   = nxt;
      cursor = nxt;
    endfunction

    function bit store_full();
      return free_head >= NIL && high_water >= NIL;
    endfunction

    function logic [DATA_W-1:0] pick_value();
      int unsigned s;
      int unsigned k;
      s = head;
      k = $urandom_range(node_count - 1);
      repeat (k) s = link_q[s];
      return data_q[s];
    endfunction

    function rsp_t apply_command(req_t r);
      int unsigned s;
      int unsigned p;
      int unsigned n;
      int unsigned i;
      rsp_t e;
      e = '0;
      e.status = ST_OK;
      case (r.cmd)
        CMD_INS_FRONT, CMD_INS_BACK: begin
          if (!take_slot(s)) begin
            e.status = ST_FULL;
          end else begin
            data_q[s] = r.value;
            if (r.cmd == CMD_INS_FRONT || head >= NIL) begin
              link_q[s] = 9'(head);
              head = s;
            end else begin
              p = head;
              for (i = 0; i < CAPACITY && next_of(p) < NIL; i++) p = next_of(p);
              link_q[s] = 9'(NIL);
              link_q[p] = 9'(s);
            end
            cursor = s;
            e.found_slot = 8'(s);
            node_count++;
          end
        end
        CMD_RM_FRONT: begin
          if (head >= NIL) e.status = ST_EMPTY;
          else drop_head();
        end
        CMD_RM_BACK: begin
          if (head >= NIL) begin
            e.status = ST_EMPTY;
          end else if (next_of(head) >= NIL) begin
            drop_head();
          end else begin
            p = head;
            n = next_of(p);
            for (i = 0; i < CAPACITY && next_of(n) < NIL; i++) begin
              p = n;
              n = next_of(n);
            end
            link_q[p] = 9'(NIL);
            release_slot(n);
            cursor = p;
          end
        end
        CMD_RM_CUR: begin
          if (head >= NIL) begin
            e.status = ST_EMPTY;
          end else if (cursor >= NIL) begin
            e.status = ST_NO_CURSOR;
          end else if (cursor == head) begin
            drop_head();
          end else begin
            p = head;
            for (i = 0; i < CAPACITY && p < NIL && next_of(p) != cursor; i++) p = next_of(p);
            if (p >= NIL || next_of(p) != cursor) begin
              e.status = ST_NO_CURSOR;
            end else begin
              link_q[p] = 9'(next_of(cursor));
              release_slot(cursor);
              cursor = p;
            end
          end
        end
        CMD_SEARCH: begin
          e.status = ST_NOT_FOUND;
          s = head;
          for (i = 0; i < CAPACITY && s < NIL; i++) begin
            if (data_q[s] == r.value) begin
              cursor = s;
              e.found_slot = 8'(s);
              e.status = ST_OK;
              break;
            end
            s = link_q[s];
          end
        end
        CMD_CLEAR: begin
          for (i = 0; i < CAPACITY && head < NIL; i++) drop_head();
          head   = NIL;
          cursor = NIL;
        end
        default: begin
          if (cursor >= NIL) e.status = ST_NO_CURSOR;
        end
      endcase
      e.cursor_valid = cursor < NIL;
      e.cursor_data  = (cursor < NIL) ? data_q[cursor] : '0;
      e.list_empty   = head >= NIL;
      return e;
    endfunction

    function void note_request(req_t r);
      pending_rsp.push_back(apply_command(r));
    endfunction

    function int unsigned pending();
      return pending_rsp.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(rsp_t got);
      rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with no request pending");
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (got.status !== exp_rsp.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, exp_rsp.status));
      if (got.found_slot !== exp_rsp.found_slot)
        report_mismatch($sformatf("found_slot got %0d want %0d",
                                  got.found_slot, exp_rsp.found_slot));
      if (got.cursor_valid !== exp_rsp.cursor_valid)
        report_mismatch($sformatf("cursor_valid got %b want %b",
                                  got.cursor_valid, exp_rsp.cursor_valid));
      if (got.cursor_data !== exp_rsp.cursor_data)
        report_mismatch($sformatf("cursor_data got %h want %h",
                                  got.cursor_data, exp_rsp.cursor_data));
      if (got.list_empty !== exp_rsp.list_empty)
        report_mismatch($sformatf("list_empty got %b want %b",
                                  got.list_empty, exp_rsp.list_empty));
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  list_tracker sb = new();

  array_linked_list_free_list #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (done_o === 1'b1) sb.check_result(rsp_o);
  end

  function automatic req_t mk(cmd_e c, logic [DATA_W-1:0] v);
    req_t r;
    r.cmd   = c;
    r.value = v;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'($urandom_range(7));
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t make_request(int mode);
    int unsigned roll;
    cmd_e c;
    logic [DATA_W-1:0] v;
    roll = $urandom_range(99);
    case (mode)
      MODE_GROW:
        c = roll < 40 ? CMD_INS_FRONT : roll < 80 ? CMD_INS_BACK : roll < 85 ? CMD_SEARCH :
            roll < 90 ? CMD_READ_CUR : roll < 93 ? CMD_RM_FRONT : roll < 96 ? CMD_RM_BACK :
            roll < 99 ? CMD_RM_CUR : CMD_READ_CUR;
      MODE_SHRINK:
        c = roll < 8 ? CMD_INS_FRONT : roll < 16 ? CMD_INS_BACK : roll < 36 ? CMD_RM_FRONT :
            roll < 56 ? CMD_RM_BACK : roll < 78 ? CMD_RM_CUR : roll < 88 ? CMD_SEARCH :
            roll < 96 ? CMD_READ_CUR : CMD_CLEAR;
      default:
        c = roll < 20 ? CMD_INS_FRONT : roll < 40 ? CMD_INS_BACK : roll < 50 ? CMD_RM_FRONT :
            roll < 60 ? CMD_RM_BACK : roll < 72 ? CMD_RM_CUR : roll < 87 ? CMD_SEARCH :
            roll < 97 ? CMD_READ_CUR : CMD_CLEAR;
    endcase
    if (c == CMD_SEARCH && sb.node_count > 0 && $urandom_range(99) < 65) v = sb.pick_value();
    else v = rand_word();
    return mk(c, v);
  endfunction

  task automatic send_request(req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic hold_off(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned idle_pct [4] = '{0, 77, 0, 33};
    int n;
    int mode;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(mk(CMD_READ_CUR, 32'h0));
    send_request(mk(CMD_RM_FRONT, 32'h0));
    send_request(mk(CMD_RM_BACK, 32'h0));
    send_request(mk(CMD_RM_CUR, 32'h0));
    send_request(mk(CMD_SEARCH, 32'h0));
    send_request(mk(CMD_CLEAR, 32'h0));
    send_request(mk(CMD_INS_FRONT, 32'h7FFF_FFFF));
    send_request(mk(CMD_INS_BACK, 32'h8000_0000));
    send_request(mk(CMD_INS_FRONT, 32'hFFFF_FFFF));
    send_request(mk(CMD_INS_BACK, 32'h0));
    send_request(mk(CMD_SEARCH, 32'h8000_0000));
    send_request(mk(CMD_SEARCH, 32'h0001_2345));
    send_request(mk(CMD_READ_CUR, 32'h0));
    send_request(mk(CMD_RM_CUR, 32'h0));
    send_request(mk(CMD_RM_BACK, 32'h0));
    send_request(mk(CMD_INS_FRONT, 32'h5555_AAAA));
    send_request(mk(CMD_RM_CUR, 32'h0));
    send_request(mk(CMD_RM_BACK, 32'h0));
    send_request(mk(CMD_RM_BACK, 32'h0));
    send_request(mk(CMD_INS_BACK, 32'hAAAA_5555));
    send_request(mk(CMD_INS_FRONT, 32'hAAAA_5555));
    send_request(mk(CMD_SEARCH, 32'hAAAA_5555));
    send_request(mk(CMD_CLEAR, 32'h0));
    send_request(mk(CMD_READ_CUR, 32'h0));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      n = 0;
      if (ph % 2 == 0) begin
        while (!sb.store_full()) begin
          hold_off(idle_pct[ph]);
          send_request(make_request(MODE_GROW));
          n++;
        end
        repeat (6) begin
          hold_off(idle_pct[ph]);
          send_request(mk($urandom_range(1) ? CMD_INS_BACK : CMD_INS_FRONT, rand_word()));
          n++;
        end
      end
      mode = MODE_MIX;
      while (n < PHASE_ITEMS) begin
        if (n % 30 == 0) mode = $urandom_range(MODE_SHRINK);
        hold_off(idle_pct[ph]);
        send_request(make_request(mode));
        n++;
      end
      wait_drained();
    end

    repeat (CAPACITY + 10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("array_linked_list_free_list_tb: done, clean");
    end else begin
      $display("array_linked_list_free_list_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("array_linked_list_free_list_tb: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
src/alfl_pkg.sv
src/alfl_ram.sv
src/array_linked_list_free_list.sv
dv/array_linked_list_free_list_tb.sv
